### rtl/core/gesture_vote_debounce_fsm_assert.svh
// ----------------------------------------------------------------------------
// Gesture vote controller assertion macros
// Clocked assertion helpers used by the port checker.
// ----------------------------------------------------------------------------
`ifndef GESTURE_VOTE_DEBOUNCE_FSM_ASSERT_SVH
`define GESTURE_VOTE_DEBOUNCE_FSM_ASSERT_SVH

// Property checked on aclk, ignored while reset is asserted.
`define GVD_ASSERT(name, prop, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Property checked on aclk, also during reset.
`define GVD_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge aclk) prop) else $error(msg);

`endif

### rtl/core/gvd_pkg.sv
// ----------------------------------------------------------------------------
// Gesture vote controller package
// Shared constants, types and lookup functions.
// ----------------------------------------------------------------------------
package gvd_pkg;

    localparam int HISTORY_DEPTH = 5;
    localparam int CNT_W         = $clog2(HISTORY_DEPTH + 1);
    localparam int PTR_W         = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int VOTE_NEEDED   = (HISTORY_DEPTH / 2) + 1;

    localparam int NUM_GESTURES  = 5;
    localparam int ACT_MARGIN    = 100;

    localparam logic [2:0] G_ROCK  = 3'd0;
    localparam logic [2:0] G_PAPER = 3'd1;
    localparam logic [2:0] G_OKAY  = 3'd2;
    localparam logic [2:0] G_REST  = 3'd3;
    localparam logic [2:0] G_OTHER = 3'd4;

    localparam logic [1:0] CAUSE_NONE    = 2'd0;
    localparam logic [1:0] CAUSE_VOTE    = 2'd1;
    localparam logic [1:0] CAUSE_TIMEOUT = 2'd2;

    localparam logic [2:0] REG_BASE0    = 3'd0;
    localparam logic [2:0] REG_BASE1    = 3'd1;
    localparam logic [2:0] REG_BASE2    = 3'd2;
    localparam logic [2:0] REG_BASE3    = 3'd3;
    localparam logic [2:0] REG_MIN_CONF = 3'd4;
    localparam logic [2:0] REG_INTERVAL = 3'd5;
    localparam logic [2:0] REG_DEBOUNCE = 3'd6;
    localparam logic [2:0] REG_INACT    = 3'd7;

    typedef struct packed {
        logic [31:0] diff;
        logic        borrow;
        logic        zero;
    } gvd_sub_t;

    function automatic logic [2:0] label_to_gesture(input logic [3:0] label);
        logic [2:0] g;
        case (label)
            4'd1, 4'd5: g = G_PAPER;
            4'd2, 4'd8: g = G_OTHER;
            4'd4:       g = G_OKAY;
            4'd7, 4'd9: g = G_ROCK;
            default:    g = G_REST;
        endcase
        return g;
    endfunction

    // {pinky, ring, middle, index, thumb}
    function automatic logic [39:0] pose_servo_word(input logic [2:0] g);
        logic [39:0] a;
        case (g)
            G_ROCK:  a = {8'd180, 8'd180, 8'd130, 8'd180, 8'd180};
            G_PAPER: a = {8'd10,  8'd80,  8'd10,  8'd10,  8'd0};
            G_OKAY:  a = {8'd10,  8'd80,  8'd10,  8'd180, 8'd180};
            G_OTHER: a = {8'd180, 8'd180, 8'd10,  8'd180, 8'd180};
            default: a = {8'd40,  8'd80,  8'd40,  8'd40,  8'd30};
        endcase
        return a;
    endfunction

endpackage

### rtl/core/gvd_sub_unit.sv
// ----------------------------------------------------------------------------
// Gesture vote controller shared subtractor
// 32-bit subtract with borrow and zero flags, reused for the activity compares and elapsed-time checks.
// ----------------------------------------------------------------------------
module gvd_sub_unit (
    input  logic [31:0]      op_a,
    input  logic [31:0]      op_b,
    output gvd_pkg::gvd_sub_t res
);

    logic [32:0] wide;

    assign wide       = {1'b0, op_a} - {1'b0, op_b};
    assign res.diff   = wide[31:0];
    assign res.borrow = wide[32];
    assign res.zero   = (wide[31:0] == 32'd0);

endmodule

### rtl/core/gesture_vote_debounce_fsm.sv
// ----------------------------------------------------------------------------
// Gesture vote and debounce controller
// Majority vote over a gesture history, activity detect, timed gating.
// ----------------------------------------------------------------------------
// One transfer in gives one transfer out. After a transfer is taken the block
// holds s_tready low while a sequencer steps through one scan step per filled
// history entry for the vote tally (1 to HISTORY_DEPTH), four channel activity
// compares and an elapsed-time step plus a compare step for each of the three
// elapsed-time checks, the compares and checks on one shared 32-bit subtractor.
// The output register is then loaded once any previous result has been taken.
// Registers are written over the APB port at byte address 4*index.
// ----------------------------------------------------------------------------
module gesture_vote_debounce_fsm (
    input  logic        aclk,
    input  logic        aresetn,
    // class_label[3:0], confidence[11:4], sample_ch0[23:12], sample_ch1[35:24],
    // sample_ch2[47:36], sample_ch3[59:48], now_ms[91:60]
    input  logic [95:0] s_tdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // gesture[2:0], change_cause[4:3], active[5], thumb_deg[13:6],
    // index_deg[21:14], middle_deg[29:22], ring_deg[37:30],
    // pinky_deg[45:38]
    output logic [47:0] m_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_ACT,
        S_ELAP,
        S_CMP,
        S_DONE
    } state_t;

    localparam int DEPTH = gvd_pkg::HISTORY_DEPTH;
    localparam int CW    = gvd_pkg::CNT_W;
    localparam int PW    = gvd_pkg::PTR_W;

    // configuration
    logic [11:0] base_reg [4];
    logic [7:0]  min_conf_reg;
    logic [15:0] interval_reg;
    logic [15:0] debounce_reg;
    logic [15:0] inact_reg;

    // item and block state
    state_t      state_reg;
    logic [7:0]  conf_reg;
    logic [11:0] samp_reg [4];
    logic [31:0] now_reg;
    logic [2:0]  hist_reg [DEPTH];
    logic [PW-1:0] ptr_reg;
    logic [CW-1:0] cnt_reg;
    logic [2:0]  cur_reg;
    logic [31:0] t_change_reg;
    logic [31:0] t_act_reg;
    logic [31:0] t_gest_reg;

    // working registers
    logic [CW-1:0] scan_idx_reg;
    logic [CW-1:0] tally_reg [gvd_pkg::NUM_GESTURES];
    logic [CW-1:0] top_reg;
    logic [2:0]  best_reg;
    logic [1:0]  act_idx_reg;
    logic [1:0]  tsel_reg;
    logic [31:0] elap_reg;
    logic        int_ok_reg;
    logic        deb_ok_reg;
    logic        inact_hit_reg;
    logic        active_reg;
    logic        m_tvalid_reg;
    logic [47:0] m_tdata_reg;

    logic [31:0]        op_a;
    logic [31:0]        op_b;
    gvd_pkg::gvd_sub_t  sub;
    logic               s_xfer;
    logic               out_load;
    logic [2:0]         in_gest;
    logic [2:0]         scan_g;
    logic [CW-1:0]      tally_inc;
    logic [2:0]         voted;
    logic [2:0]         gest_next;
    logic [1:0]         cause_next;
    logic               cfg_wr;

    assign s_tready = (state_reg == S_IDLE);
    assign s_xfer   = s_tvalid && s_tready;
    assign out_load = (state_reg == S_DONE) && (!m_tvalid_reg || m_tready);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite;

    assign in_gest   = gvd_pkg::label_to_gesture(s_tdata[3:0]);
    assign scan_g    = hist_reg[scan_idx_reg[PW-1:0]];
    assign tally_inc = tally_reg[scan_g] + CW'(1);

    // operand select for the shared subtractor
    always_comb begin
        op_a = 32'd0;
        op_b = 32'd0;
        case (state_reg)
            S_ACT: begin
                op_a = {20'd0, samp_reg[act_idx_reg]};
                op_b = {20'd0, base_reg[act_idx_reg]} + 32'(gvd_pkg::ACT_MARGIN);
            end
            S_ELAP: begin
                op_a = now_reg;
                case (tsel_reg)
                    2'd0:    op_b = t_gest_reg;
                    2'd1:    op_b = t_change_reg;
                    default: op_b = t_act_reg;
                endcase
            end
            S_CMP: begin
                op_a = elap_reg;
                case (tsel_reg)
                    2'd0:    op_b = {16'd0, interval_reg};
                    2'd1:    op_b = {16'd0, debounce_reg};
                    default: op_b = {16'd0, inact_reg};
                endcase
            end
            default: begin
                op_a = 32'd0;
                op_b = 32'd0;
            end
        endcase
    end

    gvd_sub_unit u_sub (
        .op_a (op_a),
        .op_b (op_b),
        .res  (sub)
    );

    // gesture decision
    always_comb begin
        voted      = (top_reg >= CW'(gvd_pkg::VOTE_NEEDED)) ? best_reg : cur_reg;
        gest_next  = cur_reg;
        cause_next = gvd_pkg::CAUSE_NONE;
        if ((voted != cur_reg) && (conf_reg >= min_conf_reg)) begin
            if (int_ok_reg && deb_ok_reg) begin
                gest_next  = voted;
                cause_next = gvd_pkg::CAUSE_VOTE;
            end
        end else if ((cur_reg != gvd_pkg::G_REST) && !active_reg && inact_hit_reg) begin
            gest_next  = gvd_pkg::G_REST;
            cause_next = gvd_pkg::CAUSE_TIMEOUT;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
            ptr_reg      <= '0;
            cnt_reg      <= '0;
            cur_reg      <= gvd_pkg::G_REST;
            t_change_reg <= 32'd0;
            t_act_reg    <= 32'd0;
            t_gest_reg   <= 32'd0;
            for (int i = 0; i < DEPTH; i++) begin
                hist_reg[i] <= gvd_pkg::G_REST;
            end
        end else begin
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_xfer) begin
                        conf_reg    <= s_tdata[11:4];
                        samp_reg[0] <= s_tdata[23:12];
                        samp_reg[1] <= s_tdata[35:24];
                        samp_reg[2] <= s_tdata[47:36];
                        samp_reg[3] <= s_tdata[59:48];
                        now_reg     <= s_tdata[91:60];
                        hist_reg[ptr_reg] <= in_gest;
                        ptr_reg <= (ptr_reg == PW'(DEPTH - 1)) ? '0 : ptr_reg + PW'(1);
                        if (cnt_reg < CW'(DEPTH)) begin
                            cnt_reg <= cnt_reg + CW'(1);
                        end
                        for (int g = 0; g < gvd_pkg::NUM_GESTURES; g++) begin
                            tally_reg[g] <= '0;
                        end
                        top_reg      <= '0;
                        best_reg     <= cur_reg;
                        scan_idx_reg <= '0;
                        act_idx_reg  <= 2'd0;
                        tsel_reg     <= 2'd0;
                        active_reg   <= 1'b0;
                        state_reg    <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    tally_reg[scan_g] <= tally_inc;
                    if (tally_inc > top_reg) begin
                        top_reg  <= tally_inc;
                        best_reg <= scan_g;
                    end
                    scan_idx_reg <= scan_idx_reg + CW'(1);
                    if (scan_idx_reg + CW'(1) >= cnt_reg) begin
                        state_reg <= S_ACT;
                    end
                end
                S_ACT: begin
                    if (!sub.borrow && !sub.zero) begin
                        active_reg <= 1'b1;
                    end
                    act_idx_reg <= act_idx_reg + 2'd1;
                    if (act_idx_reg == 2'd3) begin
                        state_reg <= S_ELAP;
                    end
                end
                S_ELAP: begin
                    elap_reg  <= sub.diff;
                    state_reg <= S_CMP;
                end
                S_CMP: begin
                    case (tsel_reg)
                        2'd0:    int_ok_reg    <= !sub.borrow;
                        2'd1:    deb_ok_reg    <= !sub.borrow;
                        default: inact_hit_reg <= !sub.borrow && !sub.zero;
                    endcase
                    tsel_reg <= tsel_reg + 2'd1;
                    if (tsel_reg == 2'd2) begin
                        state_reg <= S_DONE;
                    end else begin
                        state_reg <= S_ELAP;
                    end
                end
                S_DONE: begin
                    if (out_load) begin
                        m_tdata_reg  <= {2'b00, gvd_pkg::pose_servo_word(gest_next),
                                         active_reg, cause_next, gest_next};
                        cur_reg <= gest_next;
                        if (active_reg) begin
                            t_act_reg <= now_reg;
                        end
                        if (cause_next != gvd_pkg::CAUSE_NONE) begin
                            t_change_reg <= now_reg;
                        end
                        if (cause_next == gvd_pkg::CAUSE_VOTE) begin
                            t_gest_reg <= now_reg;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 4; i++) begin
                base_reg[i] <= 12'd0;
            end
            min_conf_reg <= 8'd153;
            interval_reg <= 16'd500;
            debounce_reg <= 16'd300;
            inact_reg    <= 16'd3000;
        end else if (cfg_wr) begin
            case (paddr[4:2])
                gvd_pkg::REG_BASE0:    base_reg[0]  <= pwdata[11:0];
                gvd_pkg::REG_BASE1:    base_reg[1]  <= pwdata[11:0];
                gvd_pkg::REG_BASE2:    base_reg[2]  <= pwdata[11:0];
                gvd_pkg::REG_BASE3:    base_reg[3]  <= pwdata[11:0];
                gvd_pkg::REG_MIN_CONF: min_conf_reg <= pwdata[7:0];
                gvd_pkg::REG_INTERVAL: interval_reg <= pwdata[15:0];
                gvd_pkg::REG_DEBOUNCE: debounce_reg <= pwdata[15:0];
                gvd_pkg::REG_INACT:    inact_reg    <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            gvd_pkg::REG_BASE0:    prdata = {20'd0, base_reg[0]};
            gvd_pkg::REG_BASE1:    prdata = {20'd0, base_reg[1]};
            gvd_pkg::REG_BASE2:    prdata = {20'd0, base_reg[2]};
            gvd_pkg::REG_BASE3:    prdata = {20'd0, base_reg[3]};
            gvd_pkg::REG_MIN_CONF: prdata = {24'd0, min_conf_reg};
            gvd_pkg::REG_INTERVAL: prdata = {16'd0, interval_reg};
            gvd_pkg::REG_DEBOUNCE: prdata = {16'd0, debounce_reg};
            gvd_pkg::REG_INACT:    prdata = {16'd0, inact_reg};
            default:               prdata = 32'd0;
        endcase
    end

endmodule

### rtl/core/gvd_checker.sv
// ----------------------------------------------------------------------------
// Gesture vote controller port checker
// Port-level properties of the controller, bound to the top level.
// ----------------------------------------------------------------------------
`include "gesture_vote_debounce_fsm_assert.svh"

module gvd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata
);

    logic [2:0] out_gest;
    logic [1:0] out_cause;

    assign out_gest  = m_tdata[2:0];
    assign out_cause = m_tdata[4:3];

    `GVD_ASSERT(a_out_hold, (m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)), "held")
    `GVD_ASSERT(a_busy_after_in, (s_tvalid && s_tready |=> !s_tready), "ready after transfer")
    `GVD_ASSERT(a_gesture_range, (m_tvalid |-> out_gest < 3'(gvd_pkg::NUM_GESTURES)), "gesture")
    `GVD_ASSERT(a_cause_range, (m_tvalid |-> out_cause <= gvd_pkg::CAUSE_TIMEOUT), "cause")
    `GVD_ASSERT(a_timeout_rest, (m_tvalid && out_cause == gvd_pkg::CAUSE_TIMEOUT |-> out_gest == gvd_pkg::G_REST), "timeout")

endmodule

bind gesture_vote_debounce_fsm gvd_checker u_gvd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

### tb/gesture_vote_debounce_fsm_tb.sv
// ----------------------------------------------------------------------------
// Gesture vote controller testbench
// Drives classified windows over the input stream and register settings over
// APB. A local model of the vote, activity and timing gates predicts every
// result, and a checker compares each output transfer field by field. Both
// stream sides idle at random, with a long back-pressure hold and an
// unthrottled stretch.
// ----------------------------------------------------------------------------
module gesture_vote_debounce_fsm_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;
    localparam int IDLE_PCT    = 38;

    typedef struct packed {
        logic [31:0]       now;
        logic [3:0][11:0]  ch;
        logic [7:0]        conf;
        logic [3:0]        label;
    } window_t;

    typedef struct packed {
        logic [7:0] pinky;
        logic [7:0] ring;
        logic [7:0] middle;
        logic [7:0] index;
        logic [7:0] thumb;
        logic       active;
        logic [1:0] cause;
        logic [2:0] gesture;
    } hand_result_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic [95:0] s_tdata  = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] m_tdata;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [4:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    gesture_vote_debounce_fsm uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Model copy of the register file
    logic [11:0] base_lvl [4];
    logic [7:0]  conf_floor;
    logic [15:0] change_gap_ms;
    logic [15:0] settle_ms;
    logic [15:0] quiet_limit_ms;

    // Model copy of the controller state
    logic [2:0]  vote_ring [gvd_pkg::HISTORY_DEPTH];
    int          ring_wr;
    int          ring_fill;
    logic [2:0]  hand_pose;
    logic [31:0] t_state_change;
    logic [31:0] t_last_active;
    logic [31:0] t_pose_change;

    hand_result_t hand_q[$];
    logic [31:0]  stamp_ms;

    int  sent_cnt;
    int  checked_cnt;
    int  fail_cnt;
    int  setting_cnt;
    int  cycle_cnt;
    int  hold_req;
    int  hold_left;
    bit  no_idle;

    hand_result_t seen_hand;
    hand_result_t want_hand;

    function automatic hand_result_t advance_hand(input window_t w);
        hand_result_t r;
        logic [2:0]   g;
        logic [2:0]   best;
        logic [2:0]   voted;
        int unsigned  tally [gvd_pkg::NUM_GESTURES];
        int unsigned  top;
        logic         act;
        logic [31:0]  since_pose;
        logic [31:0]  since_state;
        logic [31:0]  since_active;
        int           i;

        case (w.label)
            4'd1, 4'd5: g = gvd_pkg::G_PAPER;
            4'd2, 4'd8: g = gvd_pkg::G_OTHER;
            4'd4:       g = gvd_pkg::G_OKAY;
            4'd7, 4'd9: g = gvd_pkg::G_ROCK;
            default:    g = gvd_pkg::G_REST;
        endcase

        vote_ring[ring_wr] = g;
        ring_wr = (ring_wr == gvd_pkg::HISTORY_DEPTH - 1) ? 0 : ring_wr + 1;
        if (ring_fill < gvd_pkg::HISTORY_DEPTH) ring_fill++;

        for (i = 0; i < gvd_pkg::NUM_GESTURES; i++) tally[i] = 0;
        top  = 0;
        best = hand_pose;
        for (i = 0; i < ring_fill; i++) begin
            tally[vote_ring[i]]++;
            if (tally[vote_ring[i]] > top) begin
                top  = tally[vote_ring[i]];
                best = vote_ring[i];
            end
        end
        voted = (top >= gvd_pkg::VOTE_NEEDED) ? best : hand_pose;

        act = 1'b0;
        for (i = 0; i < 4; i++) begin
            if (int'(w.ch[i]) > int'(base_lvl[i]) + gvd_pkg::ACT_MARGIN) act = 1'b1;
        end
        if (act) t_last_active = w.now;

        since_pose   = w.now - t_pose_change;
        since_state  = w.now - t_state_change;
        since_active = w.now - t_last_active;

        r.cause = gvd_pkg::CAUSE_NONE;
        if (voted != hand_pose && w.conf >= conf_floor) begin
            if (since_pose >= change_gap_ms && since_state >= settle_ms) begin
                hand_pose      = voted;
                t_state_change = w.now;
                t_pose_change  = w.now;
                r.cause        = gvd_pkg::CAUSE_VOTE;
            end
        end else if (hand_pose != gvd_pkg::G_REST && !act && since_active > quiet_limit_ms) begin
            hand_pose      = gvd_pkg::G_REST;
            t_state_change = w.now;
            r.cause        = gvd_pkg::CAUSE_TIMEOUT;
        end

        r.gesture = hand_pose;
        r.active  = act;
        case (hand_pose)
            gvd_pkg::G_ROCK:  {r.thumb, r.index, r.middle, r.ring, r.pinky} =
                                  {8'd180, 8'd180, 8'd130, 8'd180, 8'd180};
            gvd_pkg::G_PAPER: {r.thumb, r.index, r.middle, r.ring, r.pinky} =
                                  {8'd0, 8'd10, 8'd10, 8'd80, 8'd10};
            gvd_pkg::G_OKAY:  {r.thumb, r.index, r.middle, r.ring, r.pinky} =
                                  {8'd180, 8'd180, 8'd10, 8'd80, 8'd10};
            gvd_pkg::G_OTHER: {r.thumb, r.index, r.middle, r.ring, r.pinky} =
                                  {8'd180, 8'd180, 8'd10, 8'd180, 8'd180};
            default:          {r.thumb, r.index, r.middle, r.ring, r.pinky} =
                                  {8'd30, 8'd40, 8'd40, 8'd80, 8'd40};
        endcase
        return r;
    endfunction

    function automatic window_t mk_win(input logic [3:0] label, input logic [7:0] conf,
                                       input logic [11:0] samp, input logic [31:0] now);
        window_t w;
        w.label = label;
        w.conf  = conf;
        w.ch    = {4{samp}};
        w.now   = now;
        return w;
    endfunction

    function automatic logic [3:0][11:0] draw_samples(input bit quiet);
        logic [3:0][11:0] s;
        int               lim;
        int               i;
        for (i = 0; i < 4; i++) begin
            lim = int'(base_lvl[i]) + gvd_pkg::ACT_MARGIN;
            if (lim > 4095) lim = 4095;
            if (quiet) begin
                s[i] = ($urandom_range(9) == 0) ? lim[11:0] : 12'($urandom_range(lim));
            end else if ($urandom_range(3) == 0 && lim < 4095) begin
                s[i] = 12'(lim + 1);
            end else begin
                s[i] = 12'($urandom_range(4095));
            end
        end
        return s;
    endfunction

    function automatic logic [31:0] next_stamp();
        logic [31:0] thr;
        logic [31:0] step;
        thr = (change_gap_ms > settle_ms) ? change_gap_ms : settle_ms;
        case ($urandom_range(19))
            0:          step = $urandom();
            1, 2, 3, 4: step = $urandom_range(40);
            5, 6, 7:    step = $urandom_range(32'(quiet_limit_ms) * 2 + 10);
            19:         step = $urandom_range(140000);
            default:    step = $urandom_range(thr * 2 + 10);
        endcase
        stamp_ms = stamp_ms + step;
        return stamp_ms;
    endfunction

    // Receiver: random idling, or a counted hold-off on request
    always @(posedge aclk) begin
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (no_idle) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            seen_hand = hand_result_t'(m_tdata[45:0]);
            if (hand_q.size() == 0) begin
                fail_cnt++;
                if (fail_cnt <= 10)
                    $display("unexpected result transfer: %h", m_tdata);
            end else begin
                want_hand = hand_q.pop_front();
                checked_cnt++;
                if (seen_hand.gesture !== want_hand.gesture ||
                    seen_hand.cause   !== want_hand.cause   ||
                    seen_hand.active  !== want_hand.active  ||
                    seen_hand.thumb   !== want_hand.thumb   ||
                    seen_hand.index   !== want_hand.index   ||
                    seen_hand.middle  !== want_hand.middle  ||
                    seen_hand.ring    !== want_hand.ring    ||
                    seen_hand.pinky   !== want_hand.pinky) begin
                    fail_cnt++;
                    if (fail_cnt <= 10) begin
                        $display("result %0d mismatch (exp/act): gesture %0d/%0d cause %0d/%0d",
                                 checked_cnt, want_hand.gesture, seen_hand.gesture,
                                 want_hand.cause, seen_hand.cause);
                        $display("  active %0d/%0d angles %0d %0d %0d %0d %0d / %0d %0d %0d %0d %0d",
                                 want_hand.active, seen_hand.active,
                                 want_hand.thumb, want_hand.index, want_hand.middle,
                                 want_hand.ring, want_hand.pinky,
                                 seen_hand.thumb, seen_hand.index, seen_hand.middle,
                                 seen_hand.ring, seen_hand.pinky);
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_cnt, hand_q.size());
            $display("status: fail");
            $finish;
        end
    end

    task automatic send_window(input window_t w);
        int gap;
        s_tdata  <= {4'd0, w};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        hand_q.push_back(advance_hand(w));
        sent_cnt++;
        gap = 0;
        if (!no_idle) begin
            while ($urandom_range(99) < IDLE_PCT) gap++;
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic idle_input();
        s_tvalid <= 1'b0;
    endtask

    task automatic wait_drain();
        do @(posedge aclk); while (hand_q.size() != 0);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        case (idx)
            gvd_pkg::REG_BASE0, gvd_pkg::REG_BASE1,
            gvd_pkg::REG_BASE2, gvd_pkg::REG_BASE3: base_lvl[idx] = val[11:0];
            gvd_pkg::REG_MIN_CONF: conf_floor     = val[7:0];
            gvd_pkg::REG_INTERVAL: change_gap_ms  = val[15:0];
            gvd_pkg::REG_DEBOUNCE: settle_ms      = val[15:0];
            gvd_pkg::REG_INACT:    quiet_limit_ms = val[15:0];
            default: ;
        endcase
    endtask

    // Upper bits carry junk to check register masking
    task automatic apply_setting(input logic [11:0] b0, input logic [11:0] b1,
                                 input logic [11:0] b2, input logic [11:0] b3,
                                 input logic [7:0] conf, input logic [15:0] gap,
                                 input logic [15:0] deb, input logic [15:0] inact);
        idle_input();
        wait_drain();
        repeat (24) @(posedge aclk);
        write_reg(gvd_pkg::REG_BASE0,    {20'($urandom), b0});
        write_reg(gvd_pkg::REG_BASE1,    {20'($urandom), b1});
        write_reg(gvd_pkg::REG_BASE2,    {20'($urandom), b2});
        write_reg(gvd_pkg::REG_BASE3,    {20'($urandom), b3});
        write_reg(gvd_pkg::REG_MIN_CONF, {24'($urandom), conf});
        write_reg(gvd_pkg::REG_INTERVAL, {16'($urandom), gap});
        write_reg(gvd_pkg::REG_DEBOUNCE, {16'($urandom), deb});
        write_reg(gvd_pkg::REG_INACT,    {16'($urandom), inact});
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        setting_cnt++;
    endtask

    // Mostly bursts of one label with passing confidence; the rest is noise
    task automatic run_random(input int n);
        window_t w;
        int      done;
        int      len;
        int      k;
        bit      quiet;
        logic [3:0] label;
        done = 0;
        while (done < n) begin
            if ($urandom_range(9) < 7) begin
                label = ($urandom_range(7) == 0) ? 4'($urandom_range(15, 10))
                                                 : 4'($urandom_range(9));
                len   = $urandom_range(6, 3);
                quiet = $urandom_range(1);
                for (k = 0; k < len && done < n; k++) begin
                    w.label = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : label;
                    w.conf  = ($urandom_range(4) != 0) ? 8'($urandom_range(255, conf_floor))
                                                       : 8'($urandom_range(255));
                    w.ch    = draw_samples(quiet);
                    w.now   = next_stamp();
                    send_window(w);
                    done++;
                end
            end else begin
                w.label = 4'($urandom_range(15));
                w.conf  = 8'($urandom_range(255));
                w.ch    = draw_samples($urandom_range(1));
                w.now   = ($urandom_range(9) == 0) ? $urandom() : next_stamp();
                send_window(w);
                done++;
            end
        end
    endtask

    task automatic test_directed();
        int k;
        // reset register values are in force here
        send_window(mk_win(4'd3, 8'd0, 12'd0, 32'd0));
        // three rock votes reach a majority
        send_window(mk_win(4'd7, 8'd255, 12'd4095, 32'd1000));
        send_window(mk_win(4'd7, 8'd255, 12'd4095, 32'd2000));
        send_window(mk_win(4'd7, 8'd255, 12'd4095, 32'd3000));
        // paper majority inside the gesture interval is blocked
        send_window(mk_win(4'd1, 8'd255, 12'd4095, 32'd3010));
        send_window(mk_win(4'd1, 8'd255, 12'd4095, 32'd3020));
        send_window(mk_win(4'd5, 8'd255, 12'd4095, 32'd3030));
        // low confidence, no activity, long silence: back to rest
        send_window(mk_win(4'd7, 8'd0, 12'd0, 32'd7030));
        // timestamps across the 32-bit wrap
        send_window(mk_win(4'd9, 8'd255, 12'd4095, 32'hFFFF_FF00));
        send_window(mk_win(4'd9, 8'd254, 12'd0, 32'hFFFF_FFFF));
        send_window(mk_win(4'd8, 8'd200, 12'd0, 32'h0000_0100));
        // every label, unknown ones included, with split votes on the way
        stamp_ms = 32'h0000_0100;
        for (k = 0; k < 16; k++) begin
            stamp_ms = stamp_ms + 400;
            send_window(mk_win(4'(k), k[0] ? 8'd255 : 8'd153,
                               k[1] ? 12'd4095 : 12'd0, stamp_ms));
        end
    endtask

    task automatic test_register_extremes();
        apply_setting(12'd0, 12'd0, 12'd0, 12'd0, 8'd0, 16'd0, 16'd0, 16'd0);
        run_random(100);
        apply_setting(12'd4095, 12'd4095, 12'd4095, 12'd4095,
                      8'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_random(100);
        apply_setting(12'd0, 12'd0, 12'd0, 12'd0, 8'd153, 16'd500, 16'd300, 16'd3000);
        run_random(80);
    endtask

    task automatic test_random_settings();
        int k;
        for (k = 0; k < 4; k++) begin
            apply_setting($urandom_range(1) ? 12'($urandom_range(4095)) : 12'($urandom_range(300)),
                          $urandom_range(1) ? 12'($urandom_range(4095)) : 12'($urandom_range(300)),
                          $urandom_range(1) ? 12'($urandom_range(4095)) : 12'($urandom_range(300)),
                          $urandom_range(1) ? 12'($urandom_range(4095)) : 12'($urandom_range(300)),
                          8'($urandom_range(255)), 16'($urandom_range(2000)),
                          16'($urandom_range(1000)), 16'($urandom_range(5000)));
            run_random(120);
        end
    endtask

    // Receiver holds off while the sender keeps offering, then a full drain
    task automatic test_backpressure();
        @(negedge aclk);
        hold_req = 400;
        @(posedge aclk);
        run_random(40);
        idle_input();
        wait_drain();
    endtask

    task automatic test_unthrottled();
        no_idle = 1'b1;
        run_random(100);
        idle_input();
        wait_drain();
        no_idle = 1'b0;
    endtask

    initial begin
        int i;
        for (i = 0; i < 4; i++) base_lvl[i] = 12'd0;
        conf_floor     = 8'd153;
        change_gap_ms  = 16'd500;
        settle_ms      = 16'd300;
        quiet_limit_ms = 16'd3000;
        for (i = 0; i < gvd_pkg::HISTORY_DEPTH; i++) vote_ring[i] = gvd_pkg::G_REST;
        ring_wr        = 0;
        ring_fill      = 0;
        hand_pose      = gvd_pkg::G_REST;
        t_state_change = '0;
        t_last_active  = '0;
        t_pose_change  = '0;
        stamp_ms       = '0;
        sent_cnt       = 0;
        checked_cnt    = 0;
        fail_cnt       = 0;
        setting_cnt    = 0;
        cycle_cnt      = 0;
        hold_req       = 0;
        hold_left      = 0;
        no_idle        = 1'b0;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_register_extremes();
        test_random_settings();
        test_backpressure();
        test_unthrottled();

        idle_input();
        wait_drain();
        repeat (40) @(posedge aclk);
        fail_cnt += hand_q.size();

        $display("windows sent %0d, results checked %0d, register settings %0d",
                 sent_cnt, checked_cnt, setting_cnt);
        $display("covered votes, blocked changes, timeouts, time wrap, stalls and hold-off");
        if (fail_cnt == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d failures", fail_cnt);
            $display("status: fail");
        end
        $finish;
    end

endmodule
